// ===== hdl/ibp_pkg.sv =====
// Shared types and constants for the bandstop filter / PWM compare block.
package ibp_pkg;

  // Register map (index = paddr[4:2])
  localparam int APB_AW = 5;
  localparam logic [2:0] REG_COEF_A      = 3'd0;
  localparam logic [2:0] REG_COEF_B      = 3'd1;
  localparam logic [2:0] REG_COEF_C      = 3'd2;
  localparam logic [2:0] REG_CLAMP_LIMIT = 3'd3;
  localparam logic [2:0] REG_PWM_SCALE   = 3'd4;

  localparam logic [14:0] RST_COEF_A      = 15'd30827;
  localparam logic [14:0] RST_COEF_B      = 15'd19093;
  localparam logic [14:0] RST_COEF_C      = 15'd28891;
  localparam logic [13:0] RST_CLAMP_LIMIT = 14'd16368;
  localparam logic [15:0] RST_PWM_SCALE   = 16'd2953;

  // Sample queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [14:0] coef_a;
    logic [14:0] coef_b;
    logic [14:0] coef_c;
    logic [13:0] clamp_limit;
    logic [15:0] pwm_scale;
  } cfg_t;

  typedef struct packed {
    logic mid_vld;
    logic out_vld;
  } bk_sts_t;

endpackage

// ===== hdl/ibp_front.sv =====
// Front end: converts raw converter words to a signed sample and queues it.
module ibp_front
  import ibp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_vld_i,
  output logic               s_rdy_o,
  input  logic [15:0]        sig_raw_i,
  input  logic [15:0]        ref_raw_i,
  output logic               q_vld_o,
  output logic signed [15:0] q_x_o,
  input  logic               q_pop_i
);

  logic signed [15:0] x;
  logic signed [15:0] mem_q [QDEPTH];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QAW:0]       cnt_q;
  logic               push;

  // halve both words, then signal minus reference; always fits 16 bits
  assign x = $signed({1'b0, sig_raw_i[15:1]}) - $signed({1'b0, ref_raw_i[15:1]});

  assign s_rdy_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign q_vld_o = (cnt_q != '0);
  assign q_x_o   = mem_q[rd_ptr_q];
  assign push    = s_vld_i && s_rdy_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/ibp_back.sv =====
// Back end: recursive filter step, clamp/offset/scale, output register.
module ibp_back
  import ibp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_vld_i,
  input  logic signed [15:0] q_x_i,
  output logic               q_pop_o,
  output logic               m_vld_o,
  input  logic               m_rdy_i,
  output logic [15:0]        filtered_o,
  output logic [14:0]        pwm_cmp_o,
  output bk_sts_t            sts_o
);

  // filter history: x0 oldest .. x2 newest, y2 older, y1 last
  logic signed [15:0] x0_q, x1_q, x2_q, y1_q, y2_q;
  logic               mid_vld_q, out_vld_q;
  logic signed [15:0] mid_y_q;
  logic [15:0]        out_y_q;
  logic [14:0]        out_cmp_q;

  logic signed [31:0] p_c, p_by, p_a0, p_b1, p_a2, acc;
  logic signed [15:0] y;
  logic signed [15:0] lim, clamped;
  logic [14:0]        offs;
  logic [30:0]        scaled;
  logic               out_rdy, mid_rdy;

  assign out_rdy = !out_vld_q || m_rdy_i;
  assign mid_rdy = !mid_vld_q || out_rdy;
  assign q_pop_o = q_vld_i && mid_rdy;

  // five parallel products, wrapping 32-bit sum
  assign p_c  = 32'($signed({1'b0, cfg_i.coef_c})) * 32'(y2_q);
  assign p_by = 32'($signed({1'b0, cfg_i.coef_b})) * 32'(y1_q);
  assign p_a0 = 32'($signed({1'b0, cfg_i.coef_a})) * 32'(x0_q);
  assign p_b1 = 32'($signed({1'b0, cfg_i.coef_b})) * 32'(x1_q);
  assign p_a2 = 32'($signed({1'b0, cfg_i.coef_a})) * 32'(x2_q);
  assign acc  = p_c - p_by + p_a0 - p_b1 + p_a2;
  assign y    = acc[31:16];

  // clamp to +/- limit, offset into 0..2*limit, scale
  assign lim = $signed({2'b00, cfg_i.clamp_limit});
  always_comb begin
    if (mid_y_q > lim) begin
      clamped = lim;
    end else if (mid_y_q < -lim) begin
      clamped = -lim;
    end else begin
      clamped = mid_y_q;
    end
  end
  assign offs   = 15'(clamped + lim);
  assign scaled = 31'(offs) * 31'(cfg_i.pwm_scale);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      mid_y_q <= y;
    end
    if (mid_vld_q && out_rdy) begin
      out_y_q   <= mid_y_q;
      out_cmp_q <= scaled[30:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q      <= '0;
      x1_q      <= '0;
      x2_q      <= '0;
      y1_q      <= '0;
      y2_q      <= '0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        y2_q <= y1_q;
        y1_q <= y;
        x0_q <= x1_q;
        x1_q <= x2_q;
        x2_q <= q_x_i;
      end
      if (mid_rdy) begin
        mid_vld_q <= q_vld_i;
      end
      if (out_rdy) begin
        out_vld_q <= mid_vld_q;
      end
    end
  end

  assign m_vld_o       = out_vld_q;
  assign filtered_o    = out_y_q;
  assign pwm_cmp_o     = out_cmp_q;
  assign sts_o.mid_vld = mid_vld_q;
  assign sts_o.out_vld = out_vld_q;

endmodule

// ===== hdl/iir_bandstop_to_pwm.sv =====
// Top level: register port, sample front end and filter back end.
// Path: input accept -> sample queue -> middle stage -> output register.
// Throughput: one item per cycle unless the output stalls; the output feedback loop
//   (five 15x16 products summed into the last-output register) sets the clock period.
// A 4-entry sample queue lets input and output stall independently.
// Reset (rst_ni, async low): histories, queue, pipeline cleared; registers to defaults.
module iir_bandstop_to_pwm
  import ibp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [15:0] signal_raw, [31:16] reference_raw
  // result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata   // [15:0] filtered, [30:16] pwm_compare, [31] 0
);

  cfg_t               cfg_q;
  logic [2:0]         reg_idx;
  logic               wr_en;
  logic               q_vld, q_pop;
  logic signed [15:0] q_x;
  logic [15:0]        filtered;
  logic [14:0]        pwm_cmp;
  bk_sts_t            bk_sts;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a      <= RST_COEF_A;
      cfg_q.coef_b      <= RST_COEF_B;
      cfg_q.coef_c      <= RST_COEF_C;
      cfg_q.clamp_limit <= RST_CLAMP_LIMIT;
      cfg_q.pwm_scale   <= RST_PWM_SCALE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COEF_A:      cfg_q.coef_a      <= pwdata[14:0];
        REG_COEF_B:      cfg_q.coef_b      <= pwdata[14:0];
        REG_COEF_C:      cfg_q.coef_c      <= pwdata[14:0];
        REG_CLAMP_LIMIT: cfg_q.clamp_limit <= pwdata[13:0];
        REG_PWM_SCALE:   cfg_q.pwm_scale   <= pwdata[15:0];
        default:         ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_A:      prdata = {17'd0, cfg_q.coef_a};
      REG_COEF_B:      prdata = {17'd0, cfg_q.coef_b};
      REG_COEF_C:      prdata = {17'd0, cfg_q.coef_c};
      REG_CLAMP_LIMIT: prdata = {18'd0, cfg_q.clamp_limit};
      REG_PWM_SCALE:   prdata = {16'd0, cfg_q.pwm_scale};
      default:         prdata = '0;
    endcase
  end

  // ---------------- front: sample conversion + queue ----------------
  ibp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_vld_i   (s_axis_tvalid),
    .s_rdy_o   (s_axis_tready),
    .sig_raw_i (s_axis_tdata[15:0]),
    .ref_raw_i (s_axis_tdata[31:16]),
    .q_vld_o   (q_vld),
    .q_x_o     (q_x),
    .q_pop_i   (q_pop)
  );

  // ---------------- back: filter, scale, output register ----------------
  ibp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_vld_i    (q_vld),
    .q_x_i      (q_x),
    .q_pop_o    (q_pop),
    .m_vld_o    (m_axis_tvalid),
    .m_rdy_i    (m_axis_tready),
    .filtered_o (filtered),
    .pwm_cmp_o  (pwm_cmp),
    .sts_o      (bk_sts)
  );

  assign m_axis_tdata = {1'b0, pwm_cmp, filtered};

  // ---------------- assertions ----------------
  // a full queue must be offering a sample to the back end
  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_vld)
    else $error("queue full but no sample offered");

  // every popped sample lands in the middle stage
  a_pop_fills_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> bk_sts.mid_vld)
    else $error("popped sample lost before middle stage");

  // a result appears only from a filled middle stage
  a_out_from_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(bk_sts.mid_vld))
    else $error("result valid without a sample in flight");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for iir_bandstop_to_pwm: filter predictor, stream stimulus, result check.
module tb_top;
  import ibp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;  // many times the slowest legal run
  localparam int DRAIN_WAIT  = 12;      // lets the pipe settle after the last result
  localparam int REG_SLOTS   = 1 << (APB_AW - 2);
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 210;

  // One expected result item, fields as the block packs them
  typedef struct packed {
    logic signed [15:0] filtered;
    logic [14:0]        pwm_compare;
  } filt_out_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;  // [15:0] signal_raw, [31:16] reference_raw
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [15:0] filtered, [30:16] pwm_compare, [31] 0

  iir_bandstop_to_pwm DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filter predictor: own copy of the registers and of both histories.
  // x_hist[0] is the oldest input, x_hist[2] the newest stored one;
  // y_hist[0] is the output two back, y_hist[1] the last output.
  // ---------------------------------------------------------------------
  cfg_t               model_cfg = '{coef_a: RST_COEF_A, coef_b: RST_COEF_B,
                                    coef_c: RST_COEF_C, clamp_limit: RST_CLAMP_LIMIT,
                                    pwm_scale: RST_PWM_SCALE};
  logic signed [15:0] x_hist [3] = '{16'sd0, 16'sd0, 16'sd0};
  logic signed [15:0] y_hist [2] = '{16'sd0, 16'sd0};

  filt_out_t due_outputs [$];  // results owed by the block, oldest first
  int        errors       = 0;
  int        cycle_count  = 0;
  bit        src_steady   = 1'b0;  // sender offers back to back
  bit        sink_steady  = 1'b0;  // receiver never stalls
  int        sink_hold_len = 0;    // one-shot long hold-off, taken by the receiver

  // 15-bit unsigned coefficient times 16-bit signed tap, as a 32-bit pattern
  function automatic logic [31:0] tap_product(logic [14:0] k, logic signed [15:0] s);
    int kk;
    int ss;
    kk = int'(k);
    ss = int'(s);
    return kk * ss;
  endfunction

  // Advance the predictor by one sample pair and return the result it causes
  function automatic filt_out_t run_biquad(logic [15:0] sig_raw, logic [15:0] ref_raw);
    int                 x_new;
    logic [31:0]        acc;
    logic signed [15:0] y_new;
    int                 lim;
    int                 v;
    longint             v_l;
    longint             scale_l;
    longint             prod;
    filt_out_t          res;
    x_new = int'(sig_raw >> 1) - int'(ref_raw >> 1);
    // accumulator wraps mod 2^32, no saturation anywhere
    acc = tap_product(model_cfg.coef_c, y_hist[0])
        - tap_product(model_cfg.coef_b, y_hist[1])
        + tap_product(model_cfg.coef_a, x_hist[0])
        - tap_product(model_cfg.coef_b, x_hist[1])
        + tap_product(model_cfg.coef_a, x_hist[2]);
    y_new = acc[31:16];
    y_hist[0] = y_hist[1];
    y_hist[1] = y_new;
    x_hist[0] = x_hist[1];
    x_hist[1] = x_hist[2];
    x_hist[2] = x_new[15:0];
    // symmetric clamp, offset to non-negative, then scale >> 16
    lim = int'(model_cfg.clamp_limit);
    v   = int'(y_new);
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    v       = v + lim;
    v_l     = longint'(v);
    scale_l = longint'(model_cfg.pwm_scale);
    prod    = v_l * scale_l;
    res.filtered    = y_new;
    res.pwm_compare = prod[30:16];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: random gap, then hold the item until the block takes it.
  // tvalid is left high after accept so back-to-back items never see
  // a low/high pair in one step; drain_block() lowers it.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [15:0] sig_raw, input logic [15:0] ref_raw);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ref_raw, sig_raw};
    do @(posedge clk_i); while (!s_axis_tready);
    due_outputs.push_back(run_biquad(sig_raw, ref_raw));
  endtask

  function automatic logic [15:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly full-range words; some near-balanced pairs keep x small so the
  // filter also spends time away from wrap and clamp
  task automatic send_random_sample();
    logic [15:0] s;
    logic [15:0] r;
    s = $urandom;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       begin
        s = extreme_word();
        r = extreme_word();
      end
      1, 2:    r = s + 16'($urandom_range(0, 64)) - 16'd32;
      default: ;
    endcase
    send_sample(s, r);
  endtask

  // Stop offering, wait for every owed result, then let the pipe settle
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Register write: setup phase, access phase, then an idle bus phase.
  // Only called with the block idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_COEF_A:      model_cfg.coef_a      = value[14:0];
      REG_COEF_B:      model_cfg.coef_b      = value[14:0];
      REG_COEF_C:      model_cfg.coef_c      = value[14:0];
      REG_CLAMP_LIMIT: model_cfg.clamp_limit = value[13:0];
      REG_PWM_SCALE:   model_cfg.pwm_scale   = value[15:0];
      default:         ;  // unmapped slot, write dropped
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Value for a register field: zero, full scale, small or anywhere
  function automatic logic [31:0] pick_field(int hi);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return hi;
      2:       return $urandom_range(0, hi >> 4);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Junk above the field width must be dropped by the block
  task automatic write_field(input logic [2:0] idx, input int hi);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(idx, (junk & ~32'(hi)) | pick_field(hi));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes at reset coefficients; large steps drive the wrap
  task automatic test_directed_samples();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'h0000, 16'h0001);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'hFFFE, 16'h0001);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'h0000, 16'h0000);
    drain_block();
  endtask

  // All registers at full scale, unmapped slots written, then all zero
  // (zero clamp limit forces compare value zero)
  task automatic test_register_extremes();
    int i;
    write_reg(REG_COEF_A, 32'hFFFF_FFFF);
    write_reg(REG_COEF_B, 32'hFFFF_FFFF);
    write_reg(REG_COEF_C, 32'hFFFF_FFFF);
    write_reg(REG_CLAMP_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_PWM_SCALE, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h1234, 16'h4321);
    drain_block();
    for (i = REG_PWM_SCALE + 1; i < REG_SLOTS; i++) begin
      write_reg(3'(i), $urandom);
    end
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0F0F, 16'hF0F0);
    send_sample(16'h7FFF, 16'h0000);
    drain_block();
    write_reg(REG_COEF_A, 32'h0);
    write_reg(REG_COEF_B, 32'h0);
    write_reg(REG_COEF_C, 32'h0);
    write_reg(REG_CLAMP_LIMIT, 32'h0);
    write_reg(REG_PWM_SCALE, 32'h0);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hC000, 16'h4000);
    drain_block();
  endtask

  // Several random settings, each with its own idling mix; the first
  // phase goes back to reset values
  task automatic test_random_settings();
    int p;
    int n;
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        write_reg(REG_COEF_A, 32'(RST_COEF_A));
        write_reg(REG_COEF_B, 32'(RST_COEF_B));
        write_reg(REG_COEF_C, 32'(RST_COEF_C));
        write_reg(REG_CLAMP_LIMIT, 32'(RST_CLAMP_LIMIT));
        write_reg(REG_PWM_SCALE, 32'(RST_PWM_SCALE));
      end else begin
        write_field(REG_COEF_A, 32'h7FFF);
        write_field(REG_COEF_B, 32'h7FFF);
        write_field(REG_COEF_C, 32'h7FFF);
        write_field(REG_CLAMP_LIMIT, 32'h3FFF);
        write_field(REG_PWM_SCALE, 32'hFFFF);
      end
      src_steady  = (p % 3 == 1);
      sink_steady = (p % 3 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random_sample();
      end
      drain_block();
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps
  // offering, so the sample queue fills and s_axis_tready drops
  task automatic test_output_backpressure();
    int n;
    src_steady    = 1'b1;
    sink_hold_len = 80;
    for (n = 0; n < 40; n++) begin
      send_random_sample();
    end
    src_steady = 1'b0;
    drain_block();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: per-item random stall, or the one-shot long hold-off.
  // tready is only lowered when a stall is drawn, so it never sees two
  // assignments in one step.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_len > 0) begin
        stall         = sink_hold_len;
        sink_hold_len = 0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Every accepted result against the oldest owed one
  always @(posedge clk_i) begin : check_results
    filt_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_outputs.size() == 0) begin
        $error("result item with none expected: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = due_outputs.pop_front();
        if (m_axis_tdata[15:0] !== want.filtered) begin
          $error("filtered: expected %0d, got %0d",
                 $signed(want.filtered), $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[30:16] !== want.pwm_compare) begin
          $error("pwm_compare: expected %0d, got %0d",
                 want.pwm_compare, m_axis_tdata[30:16]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL iir_bandstop_to_pwm");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_samples();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    if (errors == 0) begin
      $display("PASS iir_bandstop_to_pwm");
    end else begin
      $display("FAIL iir_bandstop_to_pwm");
    end
    $finish;
  end

endmodule
